/* hw/rtl/sep_pkg.sv */
`timescale 1ns / 1ps

package sep_pkg;

    localparam int ROWS      = 32;
    localparam int ROW_BYTES = 20;
    localparam int KEYLEN    = 20;
    localparam int POOL      = ROWS * ROW_BYTES;
    localparam int ADDR_W    = $clog2(POOL);
    localparam int CNT_W     = $clog2(POOL + 1);
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KEY_W     = $clog2(KEYLEN);
    localparam int EST_W     = 13;
    localparam int PEND_W    = 16;
    localparam int EST_MAX   = POOL * 8;
    localparam int LEN_W     = 16;
    localparam int DIG_W     = 160;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_CREDIT   = 3'd1,
        OP_READ     = 3'd2,
        OP_STIR     = 3'd3,
        OP_LOAD_KEY = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        SH_LOAD,
        SH_ROUND,
        SH_PAD
    } sha_state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } pad_t;

    typedef enum logic [2:0] {
        F_IDX,
        F_ROW,
        F_BUF,
        F_KEY,
        F_POOL
    } feed_t;

    typedef enum logic [4:0] {
        C_CLR,
        C_IDLE,
        C_RD_WAIT,
        C_DRY,
        C_STIR_START,
        C_XOR_RD,
        C_XOR_WR,
        C_ROW_INIT,
        C_KEY_INIT,
        C_FETCH,
        C_FEED,
        C_FINAL,
        C_WAIT_DIG,
        C_ROW_WR,
        C_STIR_END,
        C_DONE
    } ctl_state_t;

    typedef struct packed {
        logic       init;
        logic       byte_valid;
        logic [7:0] byte_data;
        logic       final_req;
    } sha_ctl_t;

    typedef struct packed {
        logic byte_ready;
        logic done;
    } sha_sts_t;

endpackage

/* hw/rtl/sep_sha1.sv */
`timescale 1ns / 1ps

module sep_sha1
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sep_pkg::sha_ctl_t        ctl,
    output sep_pkg::sha_sts_t        sts,
    output logic [sep_pkg::DIG_W-1:0] digest
);
    import sep_pkg::*;

    sha_state_t        state_reg, state_next;
    pad_t              pad_reg;
    logic              pad_on_reg;
    logic              last_reg;
    logic              done_reg;
    logic [31:0]       h_reg  [5];
    logic [31:0]       wv_reg [5];
    logic [511:0]      blk_reg;
    logic [5:0]        fill_reg;
    logic [LEN_W-1:0]  total_reg;
    logic [63:0]       len_reg;
    logic [2:0]        len_cnt_reg;
    logic [6:0]        round_reg;

    logic              push;
    logic [7:0]        push_byte;
    logic              block_full;
    logic [31:0]       f_val;
    logic [31:0]       k_val;
    logic [31:0]       t_val;
    logic [31:0]       w_raw;
    logic [31:0]       w_new;
    logic [31:0]       w_cur;

    always_comb
    begin
        push      = 1'b0;
        push_byte = 8'h00;
        case (state_reg)
            SH_LOAD:
            begin
                push      = ctl.byte_valid;
                push_byte = ctl.byte_data;
            end
            SH_PAD:
            begin
                case (pad_reg)
                    PAD_MARK:
                    begin
                        push      = 1'b1;
                        push_byte = 8'h80;
                    end
                    PAD_ZERO:
                    begin
                        push      = (fill_reg != 6'd56);
                        push_byte = 8'h00;
                    end
                    PAD_LEN:
                    begin
                        push      = 1'b1;
                        push_byte = len_reg[63:56];
                    end
                    default:
                    begin
                        push      = 1'b0;
                        push_byte = 8'h00;
                    end
                endcase
            end
            default:
            begin
                push      = 1'b0;
                push_byte = 8'h00;
            end
        endcase
    end

    assign block_full = push && (fill_reg == 6'd63);

    // round function
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (wv_reg[1] & wv_reg[2]) | (~wv_reg[1] & wv_reg[3]);
            k_val = 32'h5A827999;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k_val = 32'h6ED9EBA1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (wv_reg[1] & wv_reg[2]) | (wv_reg[1] & wv_reg[3]) | (wv_reg[2] & wv_reg[3]);
            k_val = 32'h8F1BBCDC;
        end
        else
        begin
            f_val = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k_val = 32'hCA62C1D6;
        end
    end

    assign w_cur = blk_reg[511:480];
    assign w_raw = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ blk_reg[511:480];
    assign w_new = {w_raw[30:0], w_raw[31]};
    assign t_val = {wv_reg[0][26:0], wv_reg[0][31:27]} + f_val + wv_reg[4] + k_val + w_cur;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SH_LOAD:
            begin
                if (ctl.init)
                    state_next = SH_LOAD;
                else if (block_full)
                    state_next = SH_ROUND;
                else if (ctl.final_req)
                    state_next = SH_PAD;
            end
            SH_ROUND:
            begin
                if (round_reg == 7'd79)
                begin
                    if (last_reg)
                        state_next = SH_LOAD;
                    else if (pad_on_reg)
                        state_next = SH_PAD;
                    else
                        state_next = SH_LOAD;
                end
            end
            SH_PAD:
            begin
                if (block_full)
                    state_next = SH_ROUND;
            end
            default:
                state_next = SH_LOAD;
        endcase
    end

    always_comb
    begin
        sts.byte_ready = (state_reg == SH_LOAD);
        sts.done       = done_reg;
        digest         = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SH_LOAD;
            pad_on_reg <= 1'b0;
            last_reg   <= 1'b0;
            done_reg   <= 1'b0;
            fill_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SH_ROUND && round_reg == 7'd79 && last_reg);
            if (state_reg == SH_LOAD && ctl.init)
            begin
                fill_reg   <= 6'd0;
                pad_on_reg <= 1'b0;
                last_reg   <= 1'b0;
            end
            else if (push)
                fill_reg <= fill_reg + 6'd1;
            if (state_reg == SH_LOAD && !ctl.init && !push && ctl.final_req)
                pad_on_reg <= 1'b1;
            if (state_reg == SH_PAD && push && pad_reg == PAD_LEN && len_cnt_reg == 3'd7)
                last_reg <= 1'b1;
            if (state_reg == SH_ROUND && round_reg == 7'd79 && last_reg)
            begin
                last_reg   <= 1'b0;
                pad_on_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SH_LOAD && ctl.init)
        begin
            h_reg[0]  <= 32'h67452301;
            h_reg[1]  <= 32'hEFCDAB89;
            h_reg[2]  <= 32'h98BADCFE;
            h_reg[3]  <= 32'h10325476;
            h_reg[4]  <= 32'hC3D2E1F0;
            total_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                blk_reg <= {blk_reg[503:0], push_byte};
                if (state_reg == SH_LOAD)
                    total_reg <= total_reg + LEN_W'(1);
            end
            if (block_full)
            begin
                for (int i = 0; i < 5; i++)
                    wv_reg[i] <= h_reg[i];
                round_reg <= 7'd0;
            end
            if (state_reg == SH_LOAD && !push && ctl.final_req)
            begin
                pad_reg     <= PAD_MARK;
                len_reg     <= {45'd0, total_reg, 3'd0};
                len_cnt_reg <= 3'd0;
            end
            if (state_reg == SH_PAD)
            begin
                case (pad_reg)
                    PAD_MARK:
                        pad_reg <= PAD_ZERO;
                    PAD_ZERO:
                    begin
                        if (fill_reg == 6'd56)
                            pad_reg <= PAD_LEN;
                    end
                    PAD_LEN:
                    begin
                        len_reg     <= {len_reg[55:0], 8'h00};
                        len_cnt_reg <= len_cnt_reg + 3'd1;
                    end
                    default:
                        pad_reg <= PAD_MARK;
                endcase
            end
            if (state_reg == SH_ROUND)
            begin
                wv_reg[0] <= t_val;
                wv_reg[1] <= wv_reg[0];
                wv_reg[2] <= {wv_reg[1][1:0], wv_reg[1][31:2]};
                wv_reg[3] <= wv_reg[2];
                wv_reg[4] <= wv_reg[3];
                blk_reg   <= {blk_reg[479:0], w_new};
                round_reg <= round_reg + 7'd1;
                if (round_reg == 7'd79)
                begin
                    h_reg[0] <= h_reg[0] + t_val;
                    h_reg[1] <= h_reg[1] + wv_reg[0];
                    h_reg[2] <= h_reg[2] + {wv_reg[1][1:0], wv_reg[1][31:2]};
                    h_reg[3] <= h_reg[3] + wv_reg[2];
                    h_reg[4] <= h_reg[4] + wv_reg[3];
                end
            end
        end
    end

endmodule

/* hw/rtl/sha1_entropy_pool.sv */
`timescale 1ns / 1ps

// entropy pool of ROWS rows of 20 bytes held in a one-port-read synchronous ram and stirred
// by an iterative sha-1 core doing one round per cycle; a stir xors any buffered bytes into the
// pool, then hashes, per row, 44 + buffered bytes (row index, row, buffer and key) and writes
// the digest back to the row, then rehashes the key over the whole pool (POOL + 20 bytes);
// after reset a clearing pass zeroes the pool before the first word is taken
module sha1_entropy_pool
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_byte, credit_bits, zero fill
    input  logic [3:0]  s_axis_tuser,  // opcode, first_of_request
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // read_byte, running_dry, entropy_estimate, stir_total, fill
);
    import sep_pkg::*;

    ctl_state_t        state_reg, state_next;
    feed_t             phase_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] xi_reg;
    logic [CNT_W-1:0]  xj_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              key_mode_reg;
    logic              ret_dry_reg;
    logic [DIG_W-1:0]  dig_reg;
    logic [7:0]        key_reg [KEYLEN];
    logic [CNT_W-1:0]  rp_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [31:0]       stir_reg;
    logic [EST_W-1:0]  cur_reg;
    logic [PEND_W-1:0] pend_reg;
    logic              dry_reg;
    logic [KEY_W-1:0]  kp_reg;
    logic [7:0]        rb_reg;
    logic              out_valid_reg;
    logic [55:0]       out_data_reg;

    logic [7:0]        pool_mem [POOL];
    logic [7:0]        buf_mem  [POOL];
    logic [7:0]        pool_rd_reg;
    logic [7:0]        buf_rd_reg;

    logic              accept;
    op_t               in_op;
    logic              in_first;
    logic [7:0]        in_data;
    logic [9:0]        in_credit;
    logic [KEY_W-1:0]  kp_eff;
    logic [KEY_W-1:0]  kp_inc;
    logic [PEND_W:0]   pend_sum;
    logic [PEND_W-1:0] pend_sat;
    logic [ADDR_W-1:0] rp_eff;
    logic [CNT_W-1:0]  rp_inc;
    logic [PEND_W:0]   est_sum;
    logic              feed_last;

    logic              pool_we;
    logic [ADDR_W-1:0] pool_waddr;
    logic [7:0]        pool_wdata;
    logic [ADDR_W-1:0] pool_raddr;
    logic [ADDR_W-1:0] buf_raddr;
    sha_ctl_t          sha_ctl;
    sha_sts_t          sha_sts;
    logic [DIG_W-1:0]  digest;

    sep_sha1 u_sha1
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (sha_ctl),
        .sts    (sha_sts),
        .digest (digest)
    );

    assign s_axis_tready = (state_reg == C_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_op         = op_t'(s_axis_tuser[2:0]);
    assign in_first      = s_axis_tuser[3];
    assign in_data       = s_axis_tdata[7:0];
    assign in_credit     = s_axis_tdata[17:8];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign kp_eff   = (in_first || kp_reg >= KEY_W'(KEYLEN)) ? '0 : kp_reg;
    assign kp_inc   = (kp_eff == KEY_W'(KEYLEN - 1)) ? '0 : kp_eff + KEY_W'(1);
    assign pend_sum = {1'b0, pend_reg} + (PEND_W + 1)'(in_credit);
    assign pend_sat = pend_sum[PEND_W] ? '1 : pend_sum[PEND_W-1:0];
    assign rp_eff   = (rp_reg >= CNT_W'(POOL)) ? '0 : rp_reg[ADDR_W-1:0];
    assign rp_inc   = CNT_W'(rp_eff) + CNT_W'(1);
    assign est_sum  = (PEND_W + 1)'(cur_reg) + (PEND_W + 1)'(pend_reg);
    assign feed_last = (phase_reg == F_KEY) && (k_reg == CNT_W'(KEYLEN - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_CLR:
            begin
                if (clr_reg == ADDR_W'(POOL - 1))
                    state_next = C_IDLE;
            end
            C_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_ADD:
                            state_next = (count_reg >= CNT_W'(POOL - 1)) ? C_STIR_START : C_DONE;
                        OP_READ:
                            state_next = C_RD_WAIT;
                        OP_STIR:
                            state_next = C_STIR_START;
                        default:
                            state_next = C_DONE;
                    endcase
                end
            end
            C_RD_WAIT:
                state_next = (rp_inc >= CNT_W'(POOL)) ? C_STIR_START : C_DRY;
            C_DRY:
            begin
                if (!dry_reg)
                    state_next = (cur_reg < EST_W'(8)) ? C_STIR_START : C_DONE;
                else
                    state_next = (pend_reg != '0) ? C_STIR_START : C_DONE;
            end
            C_STIR_START:
                state_next = (count_reg != '0) ? C_XOR_RD : C_ROW_INIT;
            C_XOR_RD:
                state_next = C_XOR_WR;
            C_XOR_WR:
                state_next = (xi_reg == ADDR_W'(POOL - 1)) ? C_ROW_INIT : C_XOR_RD;
            C_ROW_INIT:
                state_next = C_FETCH;
            C_KEY_INIT:
                state_next = C_FETCH;
            C_FETCH:
                state_next = C_FEED;
            C_FEED:
            begin
                if (sha_sts.byte_ready)
                    state_next = feed_last ? C_FINAL : C_FETCH;
            end
            C_FINAL:
            begin
                if (sha_sts.byte_ready)
                    state_next = C_WAIT_DIG;
            end
            C_WAIT_DIG:
            begin
                if (sha_sts.done)
                    state_next = key_mode_reg ? C_STIR_END : C_ROW_WR;
            end
            C_ROW_WR:
            begin
                if (k_reg == CNT_W'(ROW_BYTES - 1))
                    state_next = (row_reg == ROW_W'(ROWS - 1)) ? C_KEY_INIT : C_ROW_INIT;
            end
            C_STIR_END:
                state_next = ret_dry_reg ? C_DRY : C_DONE;
            C_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = C_IDLE;
            end
            default:
                state_next = C_IDLE;
        endcase
    end

    // memory and hash core controls
    always_comb
    begin
        pool_we    = 1'b0;
        pool_waddr = '0;
        pool_wdata = 8'h00;
        pool_raddr = '0;
        buf_raddr  = '0;
        sha_ctl    = '0;
        case (state_reg)
            C_CLR:
            begin
                pool_we    = 1'b1;
                pool_waddr = clr_reg;
            end
            C_IDLE:
                pool_raddr = rp_eff;
            C_XOR_RD:
            begin
                pool_raddr = xi_reg;
                buf_raddr  = xj_reg[ADDR_W-1:0];
            end
            C_XOR_WR:
            begin
                pool_we    = 1'b1;
                pool_waddr = xi_reg;
                pool_wdata = pool_rd_reg ^ buf_rd_reg;
            end
            C_ROW_INIT, C_KEY_INIT:
                sha_ctl.init = 1'b1;
            C_FETCH, C_FEED:
            begin
                pool_raddr = (phase_reg == F_ROW) ? base_reg + k_reg[ADDR_W-1:0]
                                                  : k_reg[ADDR_W-1:0];
                buf_raddr  = k_reg[ADDR_W-1:0];
                if (state_reg == C_FEED)
                begin
                    sha_ctl.byte_valid = 1'b1;
                    case (phase_reg)
                        F_IDX:
                            sha_ctl.byte_data = (k_reg == '0) ? 8'(row_reg) : 8'h00;
                        F_ROW, F_POOL:
                            sha_ctl.byte_data = pool_rd_reg;
                        F_BUF:
                            sha_ctl.byte_data = buf_rd_reg;
                        F_KEY:
                            sha_ctl.byte_data = key_reg[k_reg[KEY_W-1:0]];
                        default:
                            sha_ctl.byte_data = 8'h00;
                    endcase
                end
            end
            C_FINAL:
                sha_ctl.final_req = 1'b1;
            C_ROW_WR:
            begin
                pool_we    = 1'b1;
                pool_waddr = base_reg + k_reg[ADDR_W-1:0];
                pool_wdata = dig_reg[DIG_W-1 -: 8];
            end
            default:
                pool_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pool_we)
            pool_mem[pool_waddr] <= pool_wdata;
        pool_rd_reg <= pool_mem[pool_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_op == OP_ADD && count_reg < CNT_W'(POOL))
            buf_mem[count_reg[ADDR_W-1:0]] <= in_data;
        buf_rd_reg <= buf_mem[buf_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_CLR;
            clr_reg       <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            stir_reg      <= '0;
            cur_reg       <= '0;
            pend_reg      <= '0;
            dry_reg       <= 1'b1;
            kp_reg        <= '0;
            ret_dry_reg   <= 1'b0;
            key_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < KEYLEN; i++)
                key_reg[i] <= 8'h00;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready && state_reg != C_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                C_CLR:
                    clr_reg <= clr_reg + ADDR_W'(1);
                C_IDLE:
                begin
                    if (accept)
                    begin
                        rb_reg      <= (in_op == OP_READ) ? key_reg[kp_eff] : 8'h00;
                        ret_dry_reg <= 1'b0;
                        case (in_op)
                            OP_ADD:
                            begin
                                pend_reg <= pend_sat;
                                if (count_reg < CNT_W'(POOL))
                                    count_reg <= count_reg + CNT_W'(1);
                            end
                            OP_CREDIT:
                                pend_reg <= pend_sat;
                            OP_READ:
                                kp_reg <= kp_inc;
                            OP_LOAD_KEY:
                            begin
                                key_reg[kp_eff] <= in_data;
                                kp_reg          <= kp_inc;
                            end
                            default:
                                pend_reg <= pend_reg;
                        endcase
                    end
                end
                C_RD_WAIT:
                begin
                    rb_reg <= rb_reg ^ pool_rd_reg;
                    rp_reg <= rp_inc;
                    if (rp_inc >= CNT_W'(POOL))
                        ret_dry_reg <= 1'b1;
                end
                C_DRY:
                begin
                    ret_dry_reg <= 1'b0;
                    if (!dry_reg)
                    begin
                        if (cur_reg < EST_W'(8))
                        begin
                            cur_reg <= '0;
                            dry_reg <= 1'b1;
                        end
                        else
                            cur_reg <= cur_reg - EST_W'(8);
                    end
                end
                C_STIR_START:
                begin
                    xi_reg       <= '0;
                    xj_reg       <= '0;
                    row_reg      <= '0;
                    base_reg     <= '0;
                    key_mode_reg <= 1'b0;
                end
                C_XOR_WR:
                begin
                    xi_reg <= xi_reg + ADDR_W'(1);
                    xj_reg <= (xj_reg + CNT_W'(1) == count_reg) ? '0 : xj_reg + CNT_W'(1);
                end
                C_ROW_INIT:
                begin
                    phase_reg <= F_IDX;
                    k_reg     <= '0;
                end
                C_KEY_INIT:
                begin
                    phase_reg    <= F_POOL;
                    k_reg        <= '0;
                    key_mode_reg <= 1'b1;
                end
                C_FEED:
                begin
                    if (sha_sts.byte_ready)
                    begin
                        case (phase_reg)
                            F_IDX:
                            begin
                                if (k_reg == CNT_W'(3))
                                begin
                                    phase_reg <= F_ROW;
                                    k_reg     <= '0;
                                end
                                else
                                    k_reg <= k_reg + CNT_W'(1);
                            end
                            F_ROW:
                            begin
                                if (k_reg == CNT_W'(ROW_BYTES - 1))
                                begin
                                    phase_reg <= (count_reg != '0) ? F_BUF : F_KEY;
                                    k_reg     <= '0;
                                end
                                else
                                    k_reg <= k_reg + CNT_W'(1);
                            end
                            F_BUF:
                            begin
                                if (k_reg + CNT_W'(1) == count_reg)
                                begin
                                    phase_reg <= F_KEY;
                                    k_reg     <= '0;
                                end
                                else
                                    k_reg <= k_reg + CNT_W'(1);
                            end
                            F_POOL:
                            begin
                                if (k_reg == CNT_W'(POOL - 1))
                                begin
                                    phase_reg <= F_KEY;
                                    k_reg     <= '0;
                                end
                                else
                                    k_reg <= k_reg + CNT_W'(1);
                            end
                            default:
                            begin
                                phase_reg <= F_KEY;
                                k_reg     <= k_reg + CNT_W'(1);
                            end
                        endcase
                    end
                end
                C_WAIT_DIG:
                begin
                    if (sha_sts.done)
                    begin
                        dig_reg <= digest;
                        k_reg   <= '0;
                        if (key_mode_reg)
                        begin
                            for (int i = 0; i < KEYLEN; i++)
                                key_reg[i] <= digest[DIG_W-1-8*i -: 8];
                        end
                    end
                end
                C_ROW_WR:
                begin
                    dig_reg <= {dig_reg[DIG_W-9:0], 8'h00};
                    k_reg   <= k_reg + CNT_W'(1);
                    if (k_reg == CNT_W'(ROW_BYTES - 1))
                    begin
                        row_reg  <= row_reg + ROW_W'(1);
                        base_reg <= base_reg + ADDR_W'(ROW_BYTES);
                    end
                end
                C_STIR_END:
                begin
                    count_reg <= '0;
                    rp_reg    <= '0;
                    stir_reg  <= stir_reg + 32'd1;
                    pend_reg  <= '0;
                    cur_reg   <= (est_sum > (PEND_W + 1)'(EST_MAX)) ? EST_W'(EST_MAX)
                                                                   : est_sum[EST_W-1:0];
                    if (est_sum != '0)
                        dry_reg <= 1'b0;
                end
                C_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {2'b00, stir_reg, cur_reg, dry_reg, rb_reg};
                    end
                end
                default:
                    ret_dry_reg <= ret_dry_reg;
            endcase
        end
    end

endmodule
